[design/keypad_code_lock_unit_assert.svh]
// Assertion macros for the keypad code lock unit.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef KEYPAD_CODE_LOCK_UNIT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KCL_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define KCL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/kcl_pkg.sv]
// Package for the keypad code lock unit: sizes, key and message codes,
// transaction payload structs. No dependencies.
package kcl_pkg;

    localparam int SLOTS    = 4;
    localparam int CODE_LEN = 4;

    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CHAR_IW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int KCNT_W  = $clog2(CODE_LEN + 2);
    localparam int CODE_W  = 8 * CODE_LEN;

    localparam logic [KCNT_W-1:0]  CODE_LEN_K = KCNT_W'(CODE_LEN);
    localparam logic [SLOT_IW-1:0] SLOT_LAST  = SLOT_IW'(SLOTS - 1);

    localparam logic [7:0]  KEY_STAR         = 8'h2A;
    localparam logic [7:0]  KEY_HASH         = 8'h23;
    localparam logic [7:0]  KEY_ONE          = 8'h31;
    localparam logic [31:0] HOLD_TICKS_RESET = 32'd29491199;

    typedef enum logic [2:0] {
        MSG_ENTER   = 3'd0,
        MSG_BAD     = 3'd1,
        MSG_GOOD    = 3'd2,
        MSG_INVALID = 3'd3,
        MSG_VALID   = 3'd4,
        MSG_NOROOM  = 3'd5,
        MSG_SET     = 3'd6
    } t_msg;

    typedef enum logic [2:0] {
        MODE_READY = 3'd0,
        MODE_ENTER = 3'd1,
        MODE_STAR  = 3'd2,
        MODE_SET   = 3'd3,
        MODE_HOLD  = 3'd4
    } t_mode;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_code;
    } t_lock_in;

    typedef struct packed {
        t_msg       message;
        t_mode      mode;
        logic [7:0] echo_key;
        logic       echo_valid;
        logic [2:0] chars_entered;
        logic       unlock;
    } t_lock_out;

    // factory code: '1', '2', ... at ascending character positions
    function automatic logic [CODE_W-1:0] default_code();
        logic [CODE_W-1:0] code;
        code = '0;
        for (int k = 0; k < CODE_LEN; k++) begin
            code[8*k +: 8] = KEY_ONE + 8'(k);
        end
        return code;
    endfunction

endpackage

[design/keypad_code_lock_unit.sv]
// Keypad code lock: one transaction in, one result out. An accepted transaction
// goes through EXEC, then MATCH or FIND when a full code is checked or stored,
// then EMIT; the slot sequencer visits one slot per cycle through a single compare.
// No new transaction is taken until its result is loaded into the output register.
// Reset (synchronous, i_rst_n low): slot 0 = "1234", other slots empty,
// ready mode, hold_ticks = 29491199. Output register frees the input side.
module keypad_code_lock_unit
    import kcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_lock_in    i_in,
    // result transaction channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_lock_out   o_out,
    // hold_ticks register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

`include "keypad_code_lock_unit_assert.svh"

    // Sequencer: IDLE takes a transaction, EXEC decodes the key against the
    // current mode, MATCH / FIND walk the slots one per cycle, EMIT loads the
    // output register once it is free.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MATCH,
        S_FIND,
        S_EMIT
    } t_seq;

    t_seq                r_seq,        n_seq;
    logic                r_op,         n_op;
    logic [7:0]          r_key,        n_key;
    logic [31:0]         r_hold_ticks, n_hold_ticks;
    logic [CODE_W-1:0]   r_slot [SLOTS];
    logic [CODE_W-1:0]   n_slot [SLOTS];
    logic [SLOTS-1:0]    r_slot_valid, n_slot_valid;
    logic [CODE_W-1:0]   r_buf,        n_buf;
    t_mode               r_mode,       n_mode;
    logic [KCNT_W-1:0]   r_kcnt,       n_kcnt;
    logic [31:0]         r_hold_cnt,   n_hold_cnt;
    t_msg                r_msg,        n_msg;
    logic [SLOT_IW-1:0]  r_idx,        n_idx;
    // per-transaction result fields, gathered while the sequencer runs
    logic [7:0]          r_echo,       n_echo;
    logic                r_echo_v,     n_echo_v;
    logic [KCNT_W-1:0]   r_shown,      n_shown;
    logic                r_unlock,     n_unlock;
    // output register
    t_lock_out           r_out,        n_out;
    logic                r_out_valid,  n_out_valid;

    logic [31:0]         hold_inc;
    logic                is_star;
    logic                is_hash;
    logic [KCNT_W-1:0]   base_cnt;
    logic [KCNT_W-1:0]   next_cnt;
    logic [CHAR_IW-1:0]  char_idx;

    assign hold_inc = r_hold_cnt + 32'd1;
    assign is_star  = (r_key == KEY_STAR);
    assign is_hash  = (r_key == KEY_HASH);
    // a fresh sequence starts from ready
    assign base_cnt = (r_mode == MODE_READY) ? '0 : r_kcnt;
    assign next_cnt = base_cnt + KCNT_W'(1);
    assign char_idx = base_cnt[CHAR_IW-1:0];

    assign o_in_stall  = (r_seq != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_seq        = r_seq;
        n_op         = r_op;
        n_key        = r_key;
        n_hold_ticks = r_hold_ticks;
        n_slot       = r_slot;
        n_slot_valid = r_slot_valid;
        n_buf        = r_buf;
        n_mode       = r_mode;
        n_kcnt       = r_kcnt;
        n_hold_cnt   = r_hold_cnt;
        n_msg        = r_msg;
        n_idx        = r_idx;
        n_echo       = r_echo;
        n_echo_v     = r_echo_v;
        n_shown      = r_shown;
        n_unlock     = r_unlock;
        n_out        = r_out;
        n_out_valid  = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_hold_ticks = i_cfg_wdata;
        end

        unique case (r_seq)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in.opcode;
                    n_key = i_in.key_code;
                    n_seq = S_EXEC;
                end
            end

            S_EXEC: begin
                n_echo   = '0;
                n_echo_v = 1'b0;
                n_unlock = 1'b0;
                n_shown  = r_kcnt;
                n_seq    = S_EMIT;
                if (r_op) begin
                    // timer tick only counts while a verdict is held
                    if (r_mode == MODE_HOLD) begin
                        if (hold_inc >= r_hold_ticks) begin
                            n_hold_cnt = '0;
                            n_mode     = MODE_READY;
                            n_msg      = MSG_ENTER;
                            n_kcnt     = '0;
                            n_shown    = '0;
                        end else begin
                            n_hold_cnt = hold_inc;
                        end
                    end
                end else if (r_mode != MODE_HOLD) begin
                    n_echo   = r_key;
                    n_echo_v = 1'b1;
                    unique case (r_mode)
                        MODE_READY, MODE_ENTER: begin
                            if (r_mode == MODE_READY && is_star) begin
                                n_kcnt  = KCNT_W'(1);
                                n_mode  = MODE_STAR;
                                n_shown = KCNT_W'(1);
                            end else if (is_star || is_hash) begin
                                n_shown    = next_cnt;
                                n_msg      = MSG_BAD;
                                n_mode     = MODE_HOLD;
                                n_hold_cnt = '0;
                                n_kcnt     = '0;
                            end else begin
                                if (base_cnt < CODE_LEN_K) begin
                                    n_buf[{char_idx, 3'b000} +: 8] = r_key;
                                end
                                n_kcnt  = next_cnt;
                                n_shown = next_cnt;
                                n_mode  = MODE_ENTER;
                                if (next_cnt >= CODE_LEN_K) begin
                                    n_idx = '0;
                                    n_seq = S_MATCH;
                                end
                            end
                        end
                        MODE_STAR: begin
                            n_shown = KCNT_W'(2);
                            if (is_star) begin
                                n_kcnt = '0;
                                n_mode = MODE_SET;
                                n_msg  = MSG_SET;
                            end else begin
                                n_msg      = MSG_BAD;
                                n_mode     = MODE_HOLD;
                                n_hold_cnt = '0;
                                n_kcnt     = '0;
                            end
                        end
                        MODE_SET: begin
                            n_shown = next_cnt;
                            if (is_hash && r_kcnt >= CODE_LEN_K) begin
                                n_idx = '0;
                                n_seq = S_FIND;
                            end else if (is_star || is_hash || r_kcnt >= CODE_LEN_K) begin
                                n_buf      = '0;
                                n_msg      = MSG_INVALID;
                                n_mode     = MODE_HOLD;
                                n_hold_cnt = '0;
                                n_kcnt     = '0;
                            end else begin
                                n_buf[{char_idx, 3'b000} +: 8] = r_key;
                                n_kcnt = next_cnt;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_MATCH: begin
                // one slot compared per cycle
                if (r_slot_valid[r_idx] && r_slot[r_idx] == r_buf) begin
                    n_unlock   = 1'b1;
                    n_msg      = MSG_GOOD;
                    n_mode     = MODE_HOLD;
                    n_hold_cnt = '0;
                    n_kcnt     = '0;
                    n_seq      = S_EMIT;
                end else if (r_idx == SLOT_LAST) begin
                    n_msg      = MSG_BAD;
                    n_mode     = MODE_HOLD;
                    n_hold_cnt = '0;
                    n_kcnt     = '0;
                    n_seq      = S_EMIT;
                end else begin
                    n_idx = r_idx + SLOT_IW'(1);
                end
            end

            S_FIND: begin
                // first empty slot takes the new code
                if (!r_slot_valid[r_idx]) begin
                    n_slot[r_idx]       = r_buf;
                    n_slot_valid[r_idx] = 1'b1;
                    n_buf               = '0;
                    n_msg               = MSG_VALID;
                    n_mode              = MODE_HOLD;
                    n_hold_cnt          = '0;
                    n_kcnt              = '0;
                    n_seq               = S_EMIT;
                end else if (r_idx == SLOT_LAST) begin
                    n_msg      = MSG_NOROOM;
                    n_mode     = MODE_HOLD;
                    n_hold_cnt = '0;
                    n_kcnt     = '0;
                    n_seq      = S_EMIT;
                end else begin
                    n_idx = r_idx + SLOT_IW'(1);
                end
            end

            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.message       = r_msg;
                    n_out.mode          = r_mode;
                    n_out.echo_key      = r_echo;
                    n_out.echo_valid    = r_echo_v;
                    n_out.chars_entered = 3'(r_shown);
                    n_out.unlock        = r_unlock;
                    n_out_valid         = 1'b1;
                    n_seq               = S_IDLE;
                end
            end

            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= S_IDLE;
            r_hold_ticks <= HOLD_TICKS_RESET;
            for (int s = 0; s < SLOTS; s++) begin
                r_slot[s] <= (s == 0) ? default_code() : '0;
            end
            r_slot_valid <= SLOTS'(1);
            r_buf        <= '0;
            r_mode       <= MODE_READY;
            r_kcnt       <= '0;
            r_hold_cnt   <= '0;
            r_msg        <= MSG_ENTER;
            r_out_valid  <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_hold_ticks <= n_hold_ticks;
            r_slot       <= n_slot;
            r_slot_valid <= n_slot_valid;
            r_buf        <= n_buf;
            r_mode       <= n_mode;
            r_kcnt       <= n_kcnt;
            r_hold_cnt   <= n_hold_cnt;
            r_msg        <= n_msg;
            r_out_valid  <= n_out_valid;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_echo   <= n_echo;
        r_echo_v <= n_echo_v;
        r_shown  <= n_shown;
        r_unlock <= n_unlock;
        r_out    <= n_out;
    end

    // unlock is only ever paired with the good verdict
    `KCL_ASSERT_IMPLY(a_unlock_good, o_out_valid && o_out.unlock, o_out.message == MSG_GOOD, "unlock without good verdict")
    // slots fill from slot 0 upward with no holes
    `KCL_ASSERT_IMPLY(a_slots_packed, 1'b1, r_slot_valid[0] && ((r_slot_valid & (r_slot_valid + SLOTS'(1))) == '0), "slot valid bits not a packed prefix")
    // an accepted transaction makes the block busy
    `KCL_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")
    // emit with a free output register delivers and reopens the input
    `KCL_ASSERT_NEXT(a_emit_loads, r_seq == S_EMIT && !(r_out_valid && i_out_stall), o_out_valid && !o_in_stall, "emit did not load result")

endmodule
